/* src/acbd_pkg.sv */
// Shared widths, state codes and output rounding for the Alamouti 2x1
// combiner with BPSK decision. No dependencies.
package acbd_pkg;

    localparam int SAMPLE_W  = 16;                 // Q2.13 inputs, Q4.11 outputs
    localparam int COUNT_W   = 32;                 // error counter width
    localparam int PROD_W    = 2 * SAMPLE_W;       // one gain by sample product
    localparam int ACC_W     = 2 * SAMPLE_W + 2;   // sum of four products, signed
    localparam int ENERGY_W  = 2 * SAMPLE_W + 1;   // sum of four squares, unsigned
    localparam int INT_BITS  = 4;                  // integer quotient range is 16
    localparam int DEN_W     = ENERGY_W + INT_BITS;
    localparam int REM_W     = DEN_W + 1;
    localparam int QUO_W     = SAMPLE_W;           // int bits + frac bits + round bit
    localparam int CNT_W     = 5;
    localparam int PROD_STEPS = 20;                // 4 energy + 16 numerator products

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 104;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DSTEP = 3'd3;
    localparam logic [2:0] ST_DFIN  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Round the quotient (one extra bit below the output LSB) half away from
    // zero, apply the sign and saturate to the signed output range.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic [QUO_W-1:0] quo,
        input logic             neg,
        input logic             sat
    );
        logic [QUO_W:0]        rnd;
        logic [QUO_W:0]        maxpos;
        logic [QUO_W:0]        mag;
        logic [QUO_W:0]        sgn;
        rnd    = ({1'b0, quo} + (QUO_W+1)'(1)) >> 1;
        maxpos = (QUO_W+1)'((1 << (SAMPLE_W - 1)) - 1);
        if (sat) begin
            mag = neg ? (maxpos + (QUO_W+1)'(1)) : maxpos;
        end else if (!neg && rnd > maxpos) begin
            mag = maxpos;
        end else begin
            mag = rnd;
        end
        sgn = neg ? ((QUO_W+1)'(0) - mag) : mag;
        return sgn[SAMPLE_W-1:0];
    endfunction

endpackage

/* src/alamouti_combiner_bpsk_decider.sv */
// Alamouti 2x1 combiner: one shared 16x16 multiplier builds the channel
// energy and four numerators, then a restoring divider scales each numerator.
// A new input is accepted only in idle, after the last result has entered the
// output register. Each item takes 20 products through the single multiplier
// plus four 16-step divisions; zero energy or a saturating quotient skips the steps.
// Reset (i_rst_n low, synchronous) clears the sequencer, output valid and the
// error counter. Depends on acbd_pkg.
module alamouti_combiner_bpsk_decider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // gain0_re, gain0_im, gain1_re, gain1_im, rx0_re, rx0_im, rx1_re, rx1_im,
    // ref_bit0, ref_bit1, zero pad
    input  logic [acbd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // soft0_re, soft0_im, soft1_re, soft1_im, bit0, bit1, error_total, zero pad
    output logic [acbd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // channel_null
    output logic                               o_m_axis_tuser
);

    localparam int SW = acbd_pkg::SAMPLE_W;

    logic [2:0]                          r_state, n_state;
    logic [acbd_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [1:0]                          r_dnum, n_dnum;

    logic signed [SW-1:0]                r_h0r, r_h0i, r_h1r, r_h1i;
    logic signed [SW-1:0]                r_r0r, r_r0i, r_r1r, r_r1i;
    logic                                r_ref0, r_ref1;

    logic signed [SW-1:0]                mul_a, mul_b;
    logic                                mul_neg;
    logic signed [acbd_pkg::PROD_W-1:0]  r_prod;
    logic                                r_pneg;
    logic                                r_pv;
    logic [acbd_pkg::CNT_W-1:0]          r_pstep;

    logic signed [acbd_pkg::ACC_W-1:0]   r_sum;
    logic signed [acbd_pkg::ACC_W-1:0]   acc_base, acc_ext, acc_new;
    logic [acbd_pkg::ENERGY_W-1:0]       r_energy;
    logic signed [acbd_pkg::ACC_W-1:0]   r_num [0:3];
    logic signed [SW-1:0]                r_soft [0:3];

    logic [acbd_pkg::REM_W-1:0]          r_rem;
    logic [acbd_pkg::QUO_W-1:0]          r_quo;
    logic                                r_neg, r_sat;

    logic                                null_ch;
    logic [acbd_pkg::DEN_W-1:0]          den;
    logic [acbd_pkg::REM_W-1:0]          den_ext;
    logic [acbd_pkg::ACC_W-1:0]          num_mag;
    logic [acbd_pkg::REM_W-1:0]          mag_ext;
    logic [acbd_pkg::REM_W-1:0]          rem_sh;
    logic                                rem_ge;

    logic                                r_ovalid;
    logic signed [SW-1:0]                r_o0r, r_o0i, r_o1r, r_o1i;
    logic                                r_ob0, r_ob1, r_onull;
    logic [acbd_pkg::COUNT_W-1:0]        r_err;
    logic                                out_load;
    logic                                dec0, dec1;
    logic [1:0]                          mism;
    logic [acbd_pkg::COUNT_W:0]          err_sum;

    assign o_s_axis_tready = (r_state == acbd_pkg::ST_IDLE);

    // Operand select for each product step: energy first, then n0r, n0i, n1r, n1i.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (r_cnt)
            5'd0:  begin mul_a = r_h0r; mul_b = r_h0r; end
            5'd1:  begin mul_a = r_h0i; mul_b = r_h0i; end
            5'd2:  begin mul_a = r_h1r; mul_b = r_h1r; end
            5'd3:  begin mul_a = r_h1i; mul_b = r_h1i; end
            5'd4:  begin mul_a = r_h0r; mul_b = r_r1r; end
            5'd5:  begin mul_a = r_h0i; mul_b = r_r1i; end
            5'd6:  begin mul_a = r_h1r; mul_b = r_r0r; end
            5'd7:  begin mul_a = r_h1i; mul_b = r_r0i; end
            5'd8:  begin mul_a = r_h0r; mul_b = r_r1i; end
            5'd9:  begin mul_a = r_h0i; mul_b = r_r1r; mul_neg = 1'b1; end
            5'd10: begin mul_a = r_h1i; mul_b = r_r0r; end
            5'd11: begin mul_a = r_h1r; mul_b = r_r0i; mul_neg = 1'b1; end
            5'd12: begin mul_a = r_h1r; mul_b = r_r1r; end
            5'd13: begin mul_a = r_h1i; mul_b = r_r1i; end
            5'd14: begin mul_a = r_h0r; mul_b = r_r0r; mul_neg = 1'b1; end
            5'd15: begin mul_a = r_h0i; mul_b = r_r0i; mul_neg = 1'b1; end
            5'd16: begin mul_a = r_h1r; mul_b = r_r1i; end
            5'd17: begin mul_a = r_h1i; mul_b = r_r1r; mul_neg = 1'b1; end
            5'd18: begin mul_a = r_h0i; mul_b = r_r0r; mul_neg = 1'b1; end
            5'd19: begin mul_a = r_h0r; mul_b = r_r0i; end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // Accumulate the registered product; each group of four restarts the sum.
    always_comb begin
        acc_base = (r_pstep[1:0] == 2'd0) ? '0 : r_sum;
        acc_ext  = {{(acbd_pkg::ACC_W - acbd_pkg::PROD_W){r_prod[acbd_pkg::PROD_W-1]}},
                    r_prod};
        acc_new  = r_pneg ? (acc_base - acc_ext) : (acc_base + acc_ext);
    end

    // Divider datapath: one compare and subtract against energy * 16.
    always_comb begin
        null_ch = (r_energy == '0);
        den     = {r_energy, {acbd_pkg::INT_BITS{1'b0}}};
        den_ext = {1'b0, den};
        num_mag = r_num[0][acbd_pkg::ACC_W-1] ? ('0 - r_num[0]) : r_num[0];
        mag_ext = {{(acbd_pkg::REM_W - acbd_pkg::ACC_W){1'b0}}, num_mag};
        rem_sh  = {r_rem[acbd_pkg::REM_W-2:0], 1'b0};
        rem_ge  = (rem_sh >= den_ext);
    end

    // Output stage and error count.
    always_comb begin
        out_load = (r_state == acbd_pkg::ST_OUT) && (!r_ovalid || i_m_axis_tready);
        dec0     = (r_soft[0] > 0);
        dec1     = (r_soft[2] > 0);
        mism     = {1'b0, dec0 ^ r_ref0} + {1'b0, dec1 ^ r_ref1};
        err_sum  = {1'b0, r_err} + {{(acbd_pkg::COUNT_W - 1){1'b0}}, mism};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dnum  = r_dnum;
        unique case (r_state)
            acbd_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = acbd_pkg::ST_MUL;
                    n_cnt   = '0;
                end
            end
            acbd_pkg::ST_MUL: begin
                if (r_cnt < acbd_pkg::CNT_W'(acbd_pkg::PROD_STEPS)) begin
                    n_cnt = r_cnt + acbd_pkg::CNT_W'(1);
                end
                if (r_pv && r_pstep == acbd_pkg::CNT_W'(acbd_pkg::PROD_STEPS - 1)) begin
                    n_state = acbd_pkg::ST_DINIT;
                    n_dnum  = '0;
                end
            end
            acbd_pkg::ST_DINIT: begin
                n_cnt = '0;
                if (null_ch || mag_ext >= den_ext) begin
                    n_state = acbd_pkg::ST_DFIN;
                end else begin
                    n_state = acbd_pkg::ST_DSTEP;
                end
            end
            acbd_pkg::ST_DSTEP: begin
                n_cnt = r_cnt + acbd_pkg::CNT_W'(1);
                if (r_cnt == acbd_pkg::CNT_W'(acbd_pkg::QUO_W - 1)) begin
                    n_state = acbd_pkg::ST_DFIN;
                end
            end
            acbd_pkg::ST_DFIN: begin
                n_dnum = r_dnum + 2'd1;
                n_state = (r_dnum == 2'd3) ? acbd_pkg::ST_OUT : acbd_pkg::ST_DINIT;
            end
            acbd_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = acbd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = acbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= acbd_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_dnum   <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_err    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dnum  <= n_dnum;
            r_pv    <= (r_state == acbd_pkg::ST_MUL)
                    && (r_cnt < acbd_pkg::CNT_W'(acbd_pkg::PROD_STEPS));
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_err    <= err_sum[acbd_pkg::COUNT_W] ? '1 : err_sum[acbd_pkg::COUNT_W-1:0];
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == acbd_pkg::ST_IDLE && i_s_axis_tvalid) begin
            r_h0r  <= i_s_axis_tdata[SW-1:0];
            r_h0i  <= i_s_axis_tdata[2*SW-1:SW];
            r_h1r  <= i_s_axis_tdata[3*SW-1:2*SW];
            r_h1i  <= i_s_axis_tdata[4*SW-1:3*SW];
            r_r0r  <= i_s_axis_tdata[5*SW-1:4*SW];
            r_r0i  <= i_s_axis_tdata[6*SW-1:5*SW];
            r_r1r  <= i_s_axis_tdata[7*SW-1:6*SW];
            r_r1i  <= i_s_axis_tdata[8*SW-1:7*SW];
            r_ref0 <= i_s_axis_tdata[8*SW];
            r_ref1 <= i_s_axis_tdata[8*SW+1];
        end

        if (r_state == acbd_pkg::ST_MUL) begin
            r_prod  <= mul_a * mul_b;
            r_pneg  <= mul_neg;
            r_pstep <= r_cnt;
        end

        if (r_pv) begin
            r_sum <= acc_new;
            if (r_pstep[1:0] == 2'd3) begin
                if (r_pstep == acbd_pkg::CNT_W'(3)) begin
                    r_energy <= acc_new[acbd_pkg::ENERGY_W-1:0];
                end else begin
                    r_num[0] <= r_num[1];
                    r_num[1] <= r_num[2];
                    r_num[2] <= r_num[3];
                    r_num[3] <= acc_new;
                end
            end
        end

        unique case (r_state)
            acbd_pkg::ST_DINIT: begin
                r_neg <= r_num[0][acbd_pkg::ACC_W-1];
                r_rem <= mag_ext;
                r_quo <= '0;
                r_sat <= !null_ch && (mag_ext >= den_ext);
            end
            acbd_pkg::ST_DSTEP: begin
                r_rem <= rem_ge ? (rem_sh - den_ext) : rem_sh;
                r_quo <= {r_quo[acbd_pkg::QUO_W-2:0], rem_ge};
            end
            acbd_pkg::ST_DFIN: begin
                // advance both shift lines; results land in numerator order
                r_soft[0] <= r_soft[1];
                r_soft[1] <= r_soft[2];
                r_soft[2] <= r_soft[3];
                r_soft[3] <= acbd_pkg::round_sat(r_quo, r_neg, r_sat);
                r_num[0]  <= r_num[1];
                r_num[1]  <= r_num[2];
                r_num[2]  <= r_num[3];
                r_num[3]  <= r_num[0];
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_o0r   <= r_soft[0];
            r_o0i   <= r_soft[1];
            r_o1r   <= r_soft[2];
            r_o1i   <= r_soft[3];
            r_ob0   <= dec0;
            r_ob1   <= dec1;
            r_onull <= null_ch;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_onull;
    assign o_m_axis_tdata  = {{(acbd_pkg::OUT_DATA_W - 4*SW - 2 - acbd_pkg::COUNT_W){1'b0}},
                              r_err, r_ob1, r_ob0, r_o1i, r_o1r, r_o0i, r_o0r};

endmodule

/* tb/tb.sv */
// Self-checking bench for the Alamouti 2x1 combiner with BPSK decision: directed
// vectors, then randomized channel pairs, checked against an in-bench predictor.
// Depends on acbd_pkg and alamouti_combiner_bpsk_decider.
module tb;

    localparam int RANDOM_PAIRS = 1800;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int RES_W        = 4 * acbd_pkg::SAMPLE_W + 2 + 32;

    // Packed so that the cast lines up with tdata, gain0_re in the lowest bits.
    typedef struct packed {
        logic                                 ref_bit1;
        logic                                 ref_bit0;
        logic signed [acbd_pkg::SAMPLE_W-1:0] rx1_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] rx1_re;
        logic signed [acbd_pkg::SAMPLE_W-1:0] rx0_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] rx0_re;
        logic signed [acbd_pkg::SAMPLE_W-1:0] gain1_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] gain1_re;
        logic signed [acbd_pkg::SAMPLE_W-1:0] gain0_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] gain0_re;
    } t_pair_in;

    typedef struct packed {
        logic                                 channel_null;
        logic [31:0]                          error_total;
        logic                                 bit1;
        logic                                 bit0;
        logic signed [acbd_pkg::SAMPLE_W-1:0] soft1_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] soft1_re;
        logic signed [acbd_pkg::SAMPLE_W-1:0] soft0_im;
        logic signed [acbd_pkg::SAMPLE_W-1:0] soft0_re;
    } t_pair_out;

    typedef struct packed {
        t_pair_in  item;
        logic      fixed;
        t_pair_out want;
    } t_directed_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            pair_valid = 1'b0;
    logic                            pair_ready;
    logic [acbd_pkg::IN_DATA_W-1:0]  pair_data = '0;
    logic                            soft_valid;
    logic                            soft_ready = 1'b0;
    logic [acbd_pkg::OUT_DATA_W-1:0] soft_data;
    logic                            soft_user;

    logic [acbd_pkg::COUNT_W-1:0]    bit_error_total;
    t_pair_out                       pending_decisions[$];
    t_directed_row                   directed_rows[$];
    int                              mismatch_count = 0;
    int                              quiet_cycles = 0;
    bit                              src_idle_on = 1'b1;
    bit                              snk_idle_on = 1'b0;

    alamouti_combiner_bpsk_decider i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (pair_valid),
        .o_s_axis_tready (pair_ready),
        .i_s_axis_tdata  (pair_data),
        .o_m_axis_tvalid (soft_valid),
        .i_m_axis_tready (soft_ready),
        .o_m_axis_tdata  (soft_data),
        .o_m_axis_tuser  (soft_user)
    );

    initial begin
        forever #1 i_clk = !i_clk;
    end

    // num * 2^(SAMPLE_W-5) / den by long division, rounded half away from zero.
    function automatic logic signed [acbd_pkg::SAMPLE_W-1:0] scaled_quotient(
        longint          num,
        longint unsigned den
    );
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        longint          s;
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        q   = mag / den;
        r   = mag % den;
        if (q >= (1 << acbd_pkg::INT_BITS)) begin
            q = neg ? (64'd1 << (acbd_pkg::SAMPLE_W - 1))
                    : ((64'd1 << (acbd_pkg::SAMPLE_W - 1)) - 1);
        end else begin
            for (int i = 0; i < acbd_pkg::SAMPLE_W - 5; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    q = q | 1;
                    r = r - den;
                end
            end
            r = r << 1;
            if (r >= den) begin
                q = q + 1;
            end
            if (!neg && q > (64'd1 << (acbd_pkg::SAMPLE_W - 1)) - 1) begin
                q = (64'd1 << (acbd_pkg::SAMPLE_W - 1)) - 1;
            end
            if (neg && q > (64'd1 << (acbd_pkg::SAMPLE_W - 1))) begin
                q = 64'd1 << (acbd_pkg::SAMPLE_W - 1);
            end
        end
        s = neg ? -longint'(q) : longint'(q);
        return s[acbd_pkg::SAMPLE_W-1:0];
    endfunction

    // Combine one pair, decide both bits and advance the error counter.
    function automatic t_pair_out predict_combined(t_pair_in it);
        longint          h0r, h0i, h1r, h1i, r0r, r0i, r1r, r1i;
        longint unsigned energy;
        int              errs;
        t_pair_out       res;
        h0r = it.gain0_re;
        h0i = it.gain0_im;
        h1r = it.gain1_re;
        h1i = it.gain1_im;
        r0r = it.rx0_re;
        r0i = it.rx0_im;
        r1r = it.rx1_re;
        r1i = it.rx1_im;
        res = '0;
        energy = h0r * h0r + h0i * h0i + h1r * h1r + h1i * h1i;
        if (energy == 0) begin
            res.channel_null = 1'b1;
        end else begin
            res.soft0_re = scaled_quotient(h0r * r1r + h0i * r1i + h1r * r0r + h1i * r0i, energy);
            res.soft0_im = scaled_quotient(h0r * r1i - h0i * r1r + h1i * r0r - h1r * r0i, energy);
            res.soft1_re = scaled_quotient(h1r * r1r + h1i * r1i - h0r * r0r - h0i * r0i, energy);
            res.soft1_im = scaled_quotient(h1r * r1i - h1i * r1r - h0i * r0r + h0r * r0i, energy);
            res.bit0 = res.soft0_re > 0;
            res.bit1 = res.soft1_re > 0;
        end
        errs = int'(res.bit0 != it.ref_bit0) + int'(res.bit1 != it.ref_bit1);
        repeat (errs) begin
            if (bit_error_total != '1) begin
                bit_error_total = bit_error_total + 1;
            end
        end
        res.error_total = bit_error_total[31:0];
        return res;
    endfunction

    function automatic logic signed [acbd_pkg::SAMPLE_W-1:0] scaled_sample(int shift);
        logic signed [acbd_pkg::SAMPLE_W-1:0] v;
        v = acbd_pkg::SAMPLE_W'($urandom);
        return v >>> shift;
    endfunction

    function automatic t_pair_in random_pair();
        t_pair_in it;
        int       kind;
        int       gain_shift;
        int       rx_shift;
        kind       = int'($urandom_range(0, 99));
        gain_shift = (kind < 20) ? 0 : int'($urandom_range(0, 14));
        rx_shift   = (kind < 20) ? 0 : int'($urandom_range(0, 4));
        it.gain0_re = scaled_sample(gain_shift);
        it.gain0_im = scaled_sample(gain_shift);
        it.gain1_re = scaled_sample(gain_shift);
        it.gain1_im = scaled_sample(gain_shift);
        it.rx0_re   = scaled_sample(rx_shift);
        it.rx0_im   = scaled_sample(rx_shift);
        it.rx1_re   = scaled_sample(rx_shift);
        it.rx1_im   = scaled_sample(rx_shift);
        it.ref_bit0 = 1'($urandom_range(0, 1));
        it.ref_bit1 = 1'($urandom_range(0, 1));
        // Silence one or both antennas now and then.
        if ((kind >= 20 && kind < 28) || (kind >= 28 && kind < 36)) begin
            it.gain0_re = '0;
            it.gain0_im = '0;
        end
        if ((kind >= 20 && kind < 28) || (kind >= 36 && kind < 44)) begin
            it.gain1_re = '0;
            it.gain1_im = '0;
        end
        return it;
    endfunction

    task automatic add_row(t_pair_in it, bit fixed, t_pair_out want);
        directed_rows.push_back('{item: it, fixed: fixed, want: want});
    endtask

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_decision(t_pair_out got);
        t_pair_out want;
        if (pending_decisions.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_decisions.pop_front();
        compare_field("soft0_re", want.soft0_re, got.soft0_re);
        compare_field("soft0_im", want.soft0_im, got.soft0_im);
        compare_field("soft1_re", want.soft1_re, got.soft1_re);
        compare_field("soft1_im", want.soft1_im, got.soft1_im);
        compare_field("bit0", want.bit0, got.bit0);
        compare_field("bit1", want.bit1, got.bit1);
        compare_field("error_total", want.error_total, got.error_total);
        compare_field("channel_null", want.channel_null, got.channel_null);
    endfunction

    task automatic send_pair(t_pair_in it, bit fixed, t_pair_out want);
        t_pair_out predicted;
        int        gap;
        if ($urandom_range(0, 31) == 0) begin
            src_idle_on = !src_idle_on;
        end
        gap = src_idle_on ? int'($urandom_range(0, 18)) : 0;
        if (gap > 0) begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_valid <= 1'b1;
        pair_data  <= acbd_pkg::IN_DATA_W'(it);
        @(posedge i_clk);
        while (!pair_ready) @(posedge i_clk);
        // Advance the predictor on every transfer so the error count stays in step.
        predicted = predict_combined(it);
        pending_decisions.push_back(fixed ? want : predicted);
    endtask

    // Result side: random stalls, check every transfer.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                snk_idle_on = !snk_idle_on;
            end
            gap = snk_idle_on ? int'($urandom_range(0, 18)) : 0;
            if (gap > 0) begin
                soft_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            soft_ready <= 1'b1;
            @(posedge i_clk);
            while (!soft_valid) @(posedge i_clk);
            check_decision(t_pair_out'({soft_user, soft_data[RES_W-1:0]}));
        end
    end

    always @(posedge i_clk) begin
        if ((pair_valid && pair_ready) || (soft_valid && soft_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("alamouti_combiner_bpsk_decider regression: fail");
            $finish;
        end
    end

    initial begin
        bit_error_total = '0;

        // Zero channel: soft outputs and bits forced low, errors still counted.
        add_row('{default: 0}, 1'b1, '{channel_null: 1, default: 0});
        add_row('{rx0_re: 32767, rx0_im: -32768, rx1_re: -32768, rx1_im: 32767,
                  ref_bit0: 1, ref_bit1: 1, default: 0},
                1'b1, '{channel_null: 1, error_total: 2, default: 0});
        // Tiny energy: quotient saturates both ways.
        add_row('{gain0_re: 1, rx1_re: 32767, ref_bit0: 1, default: 0},
                1'b1, '{soft0_re: 32767, bit0: 1, error_total: 2, default: 0});
        add_row('{gain0_re: 1, rx1_re: -32768, default: 0},
                1'b1, '{soft0_re: -32768, error_total: 2, default: 0});
        // Positive quotient that rounds to zero decides 0.
        add_row('{gain0_re: 32767, rx1_re: 1, ref_bit0: 1, default: 0},
                1'b1, '{error_total: 3, default: 0});
        // Unit gains pass the symbol straight through.
        add_row('{gain0_re: 8192, rx1_re: 8192, ref_bit0: 1, default: 0},
                1'b1, '{soft0_re: 2048, bit0: 1, error_total: 3, default: 0});
        add_row('{gain1_re: 8192, rx0_re: 8192, ref_bit0: 1, default: 0},
                1'b1, '{soft0_re: 2048, bit0: 1, error_total: 3, default: 0});
        add_row('{gain0_re: 8192, rx0_re: 8192, default: 0},
                1'b1, '{soft1_re: -2048, error_total: 3, default: 0});

        add_row('{gain0_re: 32767, gain0_im: 32767, gain1_re: 32767, gain1_im: 32767,
                  rx0_re: 32767, rx0_im: 32767, rx1_re: 32767, rx1_im: 32767,
                  ref_bit0: 1, ref_bit1: 1}, 1'b0, '0);
        add_row('{gain0_re: -32768, gain0_im: -32768, gain1_re: -32768, gain1_im: -32768,
                  rx0_re: -32768, rx0_im: -32768, rx1_re: -32768, rx1_im: -32768,
                  ref_bit0: 0, ref_bit1: 1}, 1'b0, '0);
        add_row('{gain0_re: -32768, gain0_im: -32768, gain1_re: -32768, gain1_im: -32768,
                  rx0_re: 32767, rx0_im: 32767, rx1_re: 32767, rx1_im: 32767,
                  ref_bit0: 1, ref_bit1: 0}, 1'b0, '0);
        add_row('{gain0_re: 32767, gain0_im: -32768, gain1_re: 32767, gain1_im: -32768,
                  rx0_re: 1, rx0_im: -1, rx1_re: -32768, rx1_im: 32767,
                  ref_bit0: 0, ref_bit1: 0}, 1'b0, '0);
        add_row('{gain0_im: 8192, gain1_im: -8192, rx0_re: 4096, rx0_im: -4096,
                  rx1_re: -4096, rx1_im: 4096, ref_bit1: 1, default: 0}, 1'b0, '0);
        add_row('{gain0_re: 2048, rx1_re: 32767, ref_bit0: 1, ref_bit1: 1, default: 0},
                1'b0, '0);
        add_row('{gain0_re: 2048, rx1_re: -32768, default: 0}, 1'b0, '0);
        add_row('{gain0_re: -1, gain1_im: 1, rx0_re: 100, rx1_im: -100, ref_bit1: 1,
                  default: 0}, 1'b0, '0);
        add_row('{gain0_re: 3, gain1_im: -5, rx0_re: 7, rx0_im: -11, rx1_re: 13,
                  rx1_im: 17, default: 0}, 1'b0, '0);
        // Exact halves: ties round away from zero.
        add_row('{gain0_re: 16384, rx1_re: 4, rx1_im: 12, ref_bit0: 1, default: 0},
                1'b0, '0);
        add_row('{gain0_re: 16384, rx1_re: -4, rx1_im: -12, rx0_re: 4, rx0_im: -12,
                  default: 0}, 1'b0, '0);
        add_row('{gain0_re: 16384, rx1_re: 3, ref_bit0: 1, default: 0}, 1'b0, '0);
        add_row('{gain1_re: -32768, gain1_im: -32768, rx0_re: 5, rx0_im: -3,
                  rx1_re: -7, rx1_im: 9, ref_bit0: 1, ref_bit1: 1, default: 0}, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_pair(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
        end
        repeat (RANDOM_PAIRS) begin
            send_pair(random_pair(), 1'b0, '0);
        end
        pair_valid <= 1'b0;

        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("alamouti_combiner_bpsk_decider regression: pass");
        end else begin
            $display("alamouti_combiner_bpsk_decider regression: fail");
        end
        $finish;
    end

endmodule
